// ===== design/edm_pkg.sv =====
// edm_pkg: shared types, constants and helpers of the edit distance matcher
// no dependencies; imported by every module of the block
`default_nettype none

package edm_pkg;

   // fixed field widths
   localparam int DIST_W  = 8;
   localparam int TOTAL_W = 32;
   localparam int COUNT_W = 16;
   localparam int CMD_W   = 2;
   localparam int SYMIN_W = 8;

   // defaults for the top level parameters
   localparam int DEF_MAX_PATTERN = 32;
   localparam int DEF_SYMBOL_BITS = 8;

   // command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_EOW    = 2'd3;

   // control from the sequencer to the pattern and column stores
   typedef struct packed {
      logic restart;   // every column entry back to its address plus one
      logic col_wr;    // write one column entry
      logic pat_wr;    // write one pattern symbol
      logic rd_en;     // read column entry and pattern symbol
   } store_ctrl_type;

   // saturating increment of a column entry
   function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
      logic [DIST_W-1:0] r;
      if (v == {DIST_W{1'b1}}) begin
         r = v;
      end else begin
         r = v + DIST_W'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/edm_cell_unit.sv =====
// edm_cell_unit: one Levenshtein cell update, shared over all column entries
// depends on edm_pkg
`default_nettype none

module edm_cell_unit
   import edm_pkg::*;
#(
   parameter int SYM_W = 8
) (
   input  wire logic [DIST_W-1:0] diag,
   input  wire logic [DIST_W-1:0] above,
   input  wire logic [DIST_W-1:0] left,
   input  wire logic [SYM_W-1:0]  pat_sym,
   input  wire logic [SYM_W-1:0]  text_sym,
   output logic      [DIST_W-1:0] cell_out
);

   logic [DIST_W-1:0] min_ab;
   logic [DIST_W-1:0] min_all;

   // minimum of the three neighbours
   always_comb begin
      min_ab  = (diag < above) ? diag : above;
      min_all = (min_ab < left) ? min_ab : left;
   end

   // a matching symbol takes the diagonal for free
   always_comb begin
      if (pat_sym == text_sym) begin
         cell_out = diag;
      end else begin
         cell_out = sat_inc(min_all);
      end
   end

endmodule

`default_nettype wire

// ===== design/edm_store.sv =====
// edm_store: pattern memory and DP column memory with per-entry valid bits
// depends on edm_pkg
`default_nettype none

module edm_store
   import edm_pkg::*;
#(
   parameter int MAX_PATTERN = 32,
   parameter int SYM_W       = 8,
   localparam int IDX_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire store_ctrl_type       ctrl,
   input  wire logic [IDX_W-1:0]     wr_addr,
   input  wire logic [DIST_W-1:0]    col_wr_data,
   input  wire logic [SYM_W-1:0]     pat_wr_data,
   input  wire logic [IDX_W-1:0]     rd_addr,
   output logic      [DIST_W-1:0]    col_rd_data,
   output logic      [SYM_W-1:0]     pat_rd_data
);

   logic [DIST_W-1:0]      col_mem [MAX_PATTERN];
   logic [SYM_W-1:0]       pat_mem [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] valid_ff;
   logic [DIST_W-1:0]      col_q_ff;
   logic [SYM_W-1:0]       pat_q_ff;
   logic                   rd_valid_ff;
   logic [IDX_W-1:0]       rd_idx_ff;

   // column memory
   always_ff @(posedge clock) begin
      if (ctrl.col_wr) begin
         col_mem[wr_addr] <= col_wr_data;
      end
      if (ctrl.rd_en) begin
         col_q_ff <= col_mem[rd_addr];
      end
   end

   // pattern memory
   always_ff @(posedge clock) begin
      if (ctrl.pat_wr) begin
         pat_mem[wr_addr] <= pat_wr_data;
      end
      if (ctrl.rd_en) begin
         pat_q_ff <= pat_mem[rd_addr];
      end
   end

   // valid bits: an entry never written since restart reads as its address plus one
   always_ff @(posedge clock) begin
      if (reset || ctrl.restart) begin
         valid_ff <= '0;
      end else if (ctrl.col_wr) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
         rd_idx_ff   <= rd_addr;
      end
   end

   // entry at address a is column row a+1
   assign col_rd_data = rd_valid_ff ? col_q_ff : (DIST_W'(rd_idx_ff) + DIST_W'(1));
   assign pat_rd_data = pat_q_ff;

endmodule

`default_nettype wire

// ===== design/edit_distance_matcher_core.sv =====
// edit_distance_matcher_core: Levenshtein distance of streamed words to a stored pattern
// The input channel (req_) carries one command beat: cmd 0 clears the pattern, the
// running total, the word count and the overflow flag; cmd 1 appends req_symbol to the
// pattern (dropped and flagged once the pattern is full); cmd 2 steps the DP column with
// one text symbol; cmd 3 ends the word and produces one result beat on the rsp_ channel
// with the word's distance, the saturating total, the word count and the overflow flag.
// Only cmd 3 gives a result; cmds 0, 1 and 3 also restart the column.
// A text symbol is handled by one cell update unit that walks the column one entry per
// cycle after a read of the pattern and column memories in the prime state. With an
// empty pattern, and for every other command, a beat needs no column walk.
// The result register shows the result in the cycle after the end-of-word beat is taken.
// While that result waits, clear, append and text beats are still taken; a further
// end-of-word beat waits until the receiver takes the pending result.
// Synchronous active-high reset empties the pattern, zeroes the totals, restarts the
// column (valid bits cleared at once, no sweep) and drops any pending result.
// Depends on edm_pkg, edm_store and edm_cell_unit.
`default_nettype none

module edit_distance_matcher_core
   import edm_pkg::*;
#(
   parameter int MAX_PATTERN = DEF_MAX_PATTERN,
   parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [CMD_W-1:0]   req_cmd,
   input  wire logic [SYMIN_W-1:0] req_symbol,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic      [DIST_W-1:0]  rsp_distance,
   output logic      [TOTAL_W-1:0] rsp_total_distance,
   output logic      [COUNT_W-1:0] rsp_word_count,
   output logic                    rsp_pattern_overflow
);

   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int SYM_W = (SYMBOL_BITS < SYMIN_W) ? SYMBOL_BITS : SYMIN_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PRIME = 2'd1;
   localparam logic [1:0] ST_STEP  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [DIST_W-1:0]  row0_ff, row0_in;
   logic [DIST_W-1:0]  last_ff, last_in;
   logic [DIST_W-1:0]  diag_ff, diag_in;
   logic [DIST_W-1:0]  left_ff, left_in;
   logic [SYM_W-1:0]   sym_ff, sym_in;
   logic [TOTAL_W-1:0] sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;
   logic [TOTAL_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               req_fire;
   logic               step_last;
   logic [TOTAL_W:0]   sum_wide;
   store_ctrl_type     ctrl;
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   rd_addr;
   logic [DIST_W-1:0]  col_wr_data;
   logic [DIST_W-1:0]  above;
   logic [SYM_W-1:0]   pat_sym;
   logic [DIST_W-1:0]  cell_out;

   // a further end-of-word beat waits for the pending result to leave
   assign req_ready = (state_ff == ST_IDLE) &&
                      ((req_cmd != CMD_EOW) || !rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign step_last = ((LEN_W'(idx_ff) + LEN_W'(1)) == len_ff);
   assign sum_wide  = {1'b0, sum_ff} + (TOTAL_W + 1)'(last_ff);

   // shared cell update unit
   edm_cell_unit #(
      .SYM_W    (SYM_W)
   ) u_cell (
      .diag     (diag_ff),
      .above    (above),
      .left     (left_ff),
      .pat_sym  (pat_sym),
      .text_sym (sym_ff),
      .cell_out (cell_out)
   );

   // pattern and column memories
   edm_store #(
      .MAX_PATTERN (MAX_PATTERN),
      .SYM_W       (SYM_W)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .wr_addr     (wr_addr),
      .col_wr_data (col_wr_data),
      .pat_wr_data (req_symbol[SYM_W-1:0]),
      .rd_addr     (rd_addr),
      .col_rd_data (above),
      .pat_rd_data (pat_sym)
   );

   // store control
   always_comb begin
      ctrl         = '0;
      wr_addr      = idx_ff;
      rd_addr      = idx_ff;
      col_wr_data  = cell_out;
      ctrl.restart = req_fire && ((req_cmd == CMD_CLEAR) || (req_cmd == CMD_APPEND) ||
                                  (req_cmd == CMD_EOW));
      if (req_fire && (req_cmd == CMD_APPEND) && (len_ff < LEN_W'(MAX_PATTERN))) begin
         ctrl.pat_wr = 1'b1;
         wr_addr     = IDX_W'(len_ff);
      end
      if (state_ff == ST_PRIME) begin
         ctrl.rd_en = 1'b1;
      end
      if (state_ff == ST_STEP) begin
         ctrl.col_wr = 1'b1;
         if (!step_last) begin
            ctrl.rd_en = 1'b1;
            rd_addr    = idx_ff + IDX_W'(1);
         end
      end
   end

   // sequencer and running state
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      row0_in      = row0_ff;
      last_in      = last_ff;
      diag_in      = diag_ff;
      left_in      = left_ff;
      sym_in       = sym_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_cmd)
                  CMD_CLEAR: begin
                     len_in   = '0;
                     sum_in   = '0;
                     count_in = '0;
                     ovf_in   = 1'b0;
                     row0_in  = '0;
                     last_in  = '0;
                  end
                  CMD_APPEND: begin
                     row0_in = '0;
                     if (len_ff < LEN_W'(MAX_PATTERN)) begin
                        len_in  = len_ff + LEN_W'(1);
                        last_in = DIST_W'(len_ff) + DIST_W'(1);
                     end else begin
                        ovf_in  = 1'b1;
                        last_in = DIST_W'(len_ff);
                     end
                  end
                  CMD_TEXT: begin
                     row0_in = sat_inc(row0_ff);
                     diag_in = row0_ff;
                     left_in = sat_inc(row0_ff);
                     sym_in  = req_symbol[SYM_W-1:0];
                     idx_in  = '0;
                     if (len_ff == '0) begin
                        last_in = sat_inc(row0_ff);
                     end else begin
                        state_in = ST_PRIME;
                     end
                  end
                  CMD_EOW: begin
                     sum_in       = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} :
                                    sum_wide[TOTAL_W-1:0];
                     count_in     = (count_ff == {COUNT_W{1'b1}}) ? count_ff :
                                    count_ff + COUNT_W'(1);
                     rsp_valid_in = 1'b1;
                     rsp_dist_in  = last_ff;
                     rsp_sum_in   = sum_in;
                     rsp_count_in = count_in;
                     rsp_ovf_in   = ovf_ff;
                     row0_in      = '0;
                     last_in      = DIST_W'(len_ff);
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PRIME: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            diag_in = above;
            left_in = cell_out;
            if (step_last) begin
               last_in  = cell_out;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         row0_ff      <= '0;
         last_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         row0_ff      <= row0_in;
         last_ff      <= last_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      diag_ff      <= diag_in;
      left_ff      <= left_in;
      sym_ff       <= sym_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_distance         = rsp_dist_ff;
   assign rsp_total_distance   = rsp_sum_ff;
   assign rsp_word_count       = rsp_count_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;

   // pattern length never passes its capacity
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_PATTERN))
      else $error("pattern length beyond capacity");

   // the column walk stays inside the pattern
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (LEN_W'(idx_ff) < len_ff))
      else $error("column walk past pattern length");

   // no beat is taken while the column walk runs
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PRIME) || (state_ff == ST_STEP)) |-> !req_ready)
      else $error("beat taken during column walk");

   // a taken result leaves unless a new word end replaces it
   a_rsp_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !(req_fire && (req_cmd == CMD_EOW))) |=> !rsp_valid)
      else $error("result beat repeated");

   // a word end always produces a result
   a_eow_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_cmd == CMD_EOW)) |=> rsp_valid)
      else $error("word end without result");

endmodule

`default_nettype wire
